// ----- hw/rtl/circle_fan_vertex_generator_assert.svh -----
// Assertion macros for the circle fan vertex generator.
// CFVG_ASSERT is disabled while rst is high; CFVG_ASSERT_ALWAYS also checks during reset.
`ifndef CIRCLE_FAN_VERTEX_GENERATOR_ASSERT_SVH
`define CIRCLE_FAN_VERTEX_GENERATOR_ASSERT_SVH

`ifndef ASSERT_OFF
`define CFVG_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define CFVG_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CFVG_ASSERT(name, prop, msg)
`define CFVG_ASSERT_ALWAYS(name, prop, msg)
`endif

`endif

// ----- hw/rtl/cfvg_pkg.sv -----
package cfvg_pkg;

  // Defaults for the top-level parameters
  localparam int MAX_SIDES_DEF    = 62;
  localparam int CORDIC_STEPS_DEF = 16;

  // Field widths
  localparam int CENTER_W = 16;
  localparam int VERTEX_W = 25;
  localparam int INDEX_W  = 6;
  localparam int RADIUS_W = 14;
  localparam int SIDES_W  = 6;

  // Configuration port
  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W  = 14;
  localparam logic [CFG_INDEX_W-1:0] REG_RADIUS    = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_NUM_SIDES = 8'd1;
  localparam logic [RADIUS_W-1:0]    RADIUS_RESET    = 14'd16;
  localparam logic [SIDES_W-1:0]     NUM_SIDES_RESET = 6'd32;

  // CORDIC datapath: x/y are Q30 with headroom for radius * 2^30, z is a turn fraction
  localparam int XY_W   = 46;
  localparam int Z_W    = 32;
  localparam int GAIN_W = 30;
  localparam logic [GAIN_W-1:0] GAIN_Q30 = 30'd652032874;
  localparam int ATAN_LEN = 24;

  // atan(2^-k) in units of 2^-32 turn
  localparam logic signed [Z_W-1:0] ATAN_TURNS [ATAN_LEN] = '{
    32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756,
    32'sd42667331,  32'sd21354465,  32'sd10679838,  32'sd5340245,
    32'sd2670163,   32'sd1335087,   32'sd667544,    32'sd333772,
    32'sd166886,    32'sd83443,     32'sd41722,     32'sd20861,
    32'sd10430,     32'sd5215,      32'sd2608,      32'sd1304,
    32'sd652,       32'sd326,       32'sd163,       32'sd81
  };

  // Q30 -> Q8 rounding
  localparam int ROUND_SHIFT = 22;
  localparam int OFFSET_W    = XY_W - ROUND_SHIFT;
  localparam logic signed [XY_W-1:0] ROUND_HALF = XY_W'(64'sd1 << (ROUND_SHIFT - 1));

  // Reciprocal of the side count: 32 restoring steps for 2^32 / n
  localparam int DIV_STEPS = 32;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  // Per-vertex information that rides along the CORDIC chain
  typedef struct packed {
    logic signed [CENTER_W-1:0] cx;
    logic signed [CENTER_W-1:0] cy;
    logic [INDEX_W-1:0]         index;
    logic                       last;
    logic                       center;
    logic [1:0]                 quad;
  } vtx_tag_t;

  // One slot of the cell chain
  typedef struct packed {
    logic                   valid;
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
    vtx_tag_t               tag;
  } stage_t;

endpackage

// ----- hw/rtl/cfvg_center_if.sv -----
interface cfvg_center_if import cfvg_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [CENTER_W-1:0] center_x;
  logic signed [CENTER_W-1:0] center_y;

  modport source (output valid, output center_x, output center_y, input ready);
  modport sink   (input valid, input center_x, input center_y, output ready);
endinterface

// ----- hw/rtl/cfvg_vertex_if.sv -----
interface cfvg_vertex_if import cfvg_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [VERTEX_W-1:0] vertex_x;
  logic signed [VERTEX_W-1:0] vertex_y;
  logic [INDEX_W-1:0]         vertex_index;
  logic                       last;

  modport source (output valid, output vertex_x, output vertex_y, output vertex_index,
                  output last, input ready);
  modport sink   (input valid, input vertex_x, input vertex_y, input vertex_index,
                  input last, output ready);
endinterface

// ----- hw/rtl/cfvg_cfg_if.sv -----
interface cfvg_cfg_if import cfvg_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- hw/rtl/cfvg_cordic_cell.sv -----
module cfvg_cordic_cell
  import cfvg_pkg::*;
#(
  parameter int SHIFT = 0
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   adv,
  input  stage_t s_in,
  output stage_t s_out
);

  logic signed [XY_W-1:0] dx;
  logic signed [XY_W-1:0] dy;
  logic                   z_neg;

  // One rotation-mode micro-rotation with a fixed shift
  assign dx    = s_in.y >>> SHIFT;
  assign dy    = s_in.x >>> SHIFT;
  assign z_neg = s_in.z[Z_W-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      s_out.valid <= 1'b0;
    end else if (adv) begin
      s_out.valid <= s_in.valid;
    end
    if (adv) begin
      s_out.tag <= s_in.tag;
      if (z_neg) begin
        s_out.x <= s_in.x + dx;
        s_out.y <= s_in.y - dy;
        s_out.z <= s_in.z + ATAN_TURNS[SHIFT];
      end else begin
        s_out.x <= s_in.x - dx;
        s_out.y <= s_in.y + dy;
        s_out.z <= s_in.z - ATAN_TURNS[SHIFT];
      end
    end
  end

endmodule

// ----- hw/rtl/cfvg_seq.sv -----
`include "circle_fan_vertex_generator_assert.svh"

module cfvg_seq
  import cfvg_pkg::*;
#(
  parameter int MAX_SIDES = MAX_SIDES_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  cfvg_center_if.sink            center,
  input  logic [SIDES_W-1:0]     num_sides,
  input  logic signed [XY_W-1:0] x0,
  input  logic                   adv,
  output stage_t                 inj
);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_DIVIDE = 3'b010,
    ST_EMIT   = 3'b100
  } seq_state_t;

  localparam logic [SIDES_W-1:0] MIN_N = SIDES_W'(3);
  localparam logic [SIDES_W-1:0] MAX_N = SIDES_W'(MAX_SIDES);

  seq_state_t              state;
  logic signed [CENTER_W-1:0] cx;
  logic signed [CENTER_W-1:0] cy;
  logic [SIDES_W-1:0]      n_eff;
  logic [SIDES_W-1:0]      n_in;
  logic [DIV_CNT_W-1:0]    cnt;
  logic [SIDES_W-1:0]      rdiv;    // divider remainder, then 2^32 mod n
  logic [Z_W-1:0]          quo;     // floor(2^32 / n)
  logic [Z_W-1:0]          phase;
  logic [SIDES_W-1:0]      racc;    // running remainder of the phase
  logic [INDEX_W-1:0]      idx;

  logic [SIDES_W:0]        div_t;
  logic                    div_ge;
  logic [SIDES_W:0]        rsum;
  logic                    carry;
  logic [INDEX_W-1:0]      idx_inc;
  logic                    is_last;

  // Side count clamp at accept
  always_comb begin
    if (num_sides < MIN_N) begin
      n_in = MIN_N;
    end else if (num_sides > MAX_N) begin
      n_in = MAX_N;
    end else begin
      n_in = num_sides;
    end
  end

  // Restoring divide step
  assign div_t  = {rdiv, 1'b0};
  assign div_ge = div_t >= {1'b0, n_eff};

  // Phase accumulator step: phase += Q plus carry out of the remainder
  assign rsum    = {1'b0, racc} + {1'b0, rdiv};
  assign carry   = rsum >= {1'b0, n_eff};
  assign idx_inc = idx + INDEX_W'(1);
  assign is_last = idx == INDEX_W'({1'b0, n_eff} + 7'd1);

  assign center.ready = state == ST_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (center.valid) begin
            state <= ST_DIVIDE;
          end
        end
        ST_DIVIDE: begin
          if (cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (adv && is_last) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end

    // Datapath registers
    case (state)
      ST_IDLE: begin
        cx    <= center.center_x;
        cy    <= center.center_y;
        n_eff <= n_in;
        rdiv  <= SIDES_W'(1);
        quo   <= '0;
        cnt   <= '0;
      end
      ST_DIVIDE: begin
        rdiv  <= div_ge ? SIDES_W'(div_t - {1'b0, n_eff}) : div_t[SIDES_W-1:0];
        quo   <= {quo[Z_W-2:0], div_ge};
        cnt   <= cnt + DIV_CNT_W'(1);
        phase <= '0;
        racc  <= n_eff >> 1;
        idx   <= '0;
      end
      ST_EMIT: begin
        if (adv && !is_last) begin
          idx <= idx_inc;
          if (idx_inc == n_eff) begin
            // rim wraps to angle zero
            phase <= '0;
            racc  <= n_eff >> 1;
          end else begin
            phase <= phase + quo + Z_W'(carry);
            racc  <= carry ? SIDES_W'(rsum - {1'b0, n_eff}) : rsum[SIDES_W-1:0];
          end
        end
      end
      default: begin
        cnt <= '0;
      end
    endcase
  end

  // Head of the chain
  always_comb begin
    inj.valid      = state == ST_EMIT;
    inj.x          = x0;
    inj.y          = '0;
    inj.z          = signed'({2'b00, phase[Z_W-3:0]});
    inj.tag.cx     = cx;
    inj.tag.cy     = cy;
    inj.tag.index  = idx;
    inj.tag.last   = is_last;
    inj.tag.center = idx == '0;
    inj.tag.quad   = phase[Z_W-1:Z_W-2];
  end

  `CFVG_ASSERT(a_racc_below_n, (state == ST_EMIT) |-> (racc < n_eff), "phase remainder reached n")
  `CFVG_ASSERT(a_n_clamped, (state != ST_IDLE) |-> (n_eff >= MIN_N && n_eff <= MAX_N), "side count out of range")
  `CFVG_ASSERT(a_idx_bound, inj.valid |-> ({1'b0, idx} <= {1'b0, n_eff} + 7'd1), "vertex index past fan end")

endmodule

// ----- hw/rtl/circle_fan_vertex_generator.sv -----
// Flow: the 32-step reciprocal of the side count is computed after the input transfer;
// each vertex then passes CORDIC_STEPS chain cells and the output register.
// An item gives n + 2 vertices (n = clamped side count), one vertex per cycle while
// the output is taken; the serial divide and the one-item sequencer mean a new centre
// is accepted only after the last vertex of the previous item has entered the chain.
// Reset (synchronous, rst high): control and valid bits cleared, radius 16, num_sides 32.
`include "circle_fan_vertex_generator_assert.svh"

module circle_fan_vertex_generator
  import cfvg_pkg::*;
#(
  parameter int MAX_SIDES    = MAX_SIDES_DEF,
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  cfvg_cfg_if.sink      cfg,
  cfvg_center_if.sink   center,
  cfvg_vertex_if.source vertex
);

  logic [RADIUS_W-1:0]          radius;
  logic [SIDES_W-1:0]           num_sides;
  logic [RADIUS_W+GAIN_W-1:0]   gain_prod;
  logic signed [XY_W-1:0]       x0;
  logic                         adv;
  stage_t                       chain [CORDIC_STEPS+1];
  stage_t                       s_last;
  logic signed [XY_W-1:0]       ox;
  logic signed [XY_W-1:0]       oy;
  logic signed [XY_W-1:0]       ox_r;
  logic signed [XY_W-1:0]       oy_r;
  logic signed [OFFSET_W-1:0]   off_x;
  logic signed [OFFSET_W-1:0]   off_y;

  // Configuration registers
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius    <= RADIUS_RESET;
      num_sides <= NUM_SIDES_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_RADIUS:    radius    <= cfg.data[RADIUS_W-1:0];
        REG_NUM_SIDES: num_sides <= cfg.data[SIDES_W-1:0];
        default: ;
      endcase
    end
  end

  // Start vector: radius scaled by the CORDIC gain, Q30
  assign gain_prod = (RADIUS_W+GAIN_W)'(radius) * (RADIUS_W+GAIN_W)'(GAIN_Q30);

  always_ff @(posedge clk) begin
    x0 <= signed'({{(XY_W-RADIUS_W-GAIN_W){1'b0}}, gain_prod});
  end

  // Whole chain moves together; it stalls only when the output register is held
  assign adv = !vertex.valid || vertex.ready;

  cfvg_seq #(
    .MAX_SIDES (MAX_SIDES)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .center    (center),
    .num_sides (num_sides),
    .x0        (x0),
    .adv       (adv),
    .inj       (chain[0])
  );

  // Row of micro-rotation cells
  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cell
    cfvg_cordic_cell #(
      .SHIFT (k)
    ) u_cell (
      .clk   (clk),
      .rst   (rst),
      .adv   (adv),
      .s_in  (chain[k]),
      .s_out (chain[k+1])
    );
  end

  assign s_last = chain[CORDIC_STEPS];

  // Quadrant mapping
  always_comb begin
    case (s_last.tag.quad)
      2'd0: begin
        ox = s_last.x;
        oy = s_last.y;
      end
      2'd1: begin
        ox = -s_last.y;
        oy = s_last.x;
      end
      2'd2: begin
        ox = -s_last.x;
        oy = -s_last.y;
      end
      default: begin
        ox = s_last.y;
        oy = -s_last.x;
      end
    endcase
  end

  // Round Q30 to Q8, half up; center vertex has no offset
  assign ox_r  = ox + ROUND_HALF;
  assign oy_r  = oy + ROUND_HALF;
  assign off_x = s_last.tag.center ? '0 : ox_r[XY_W-1:ROUND_SHIFT];
  assign off_y = s_last.tag.center ? '0 : oy_r[XY_W-1:ROUND_SHIFT];

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      vertex.valid <= 1'b0;
    end else if (adv) begin
      vertex.valid <= s_last.valid;
    end
    if (adv) begin
      vertex.vertex_x     <= {s_last.tag.cx[CENTER_W-1], s_last.tag.cx, 8'd0}
                             + {off_x[OFFSET_W-1], off_x};
      vertex.vertex_y     <= {s_last.tag.cy[CENTER_W-1], s_last.tag.cy, 8'd0}
                             + {off_y[OFFSET_W-1], off_y};
      vertex.vertex_index <= s_last.tag.index;
      vertex.last         <= s_last.tag.last;
    end
  end

  `CFVG_ASSERT(a_center_not_last, (vertex.valid && vertex.vertex_index == '0) |-> !vertex.last, "centre vertex flagged last")
  `CFVG_ASSERT(a_last_index, (vertex.valid && vertex.last) |-> (vertex.vertex_index >= INDEX_W'(4) && vertex.vertex_index <= INDEX_W'(MAX_SIDES + 1)), "last vertex index out of range")
  `CFVG_ASSERT_ALWAYS(a_reset_empty, rst |=> !vertex.valid, "output valid after reset")
  `CFVG_ASSERT(a_out_hold, (vertex.valid && !vertex.ready) |=> (vertex.valid && $stable(vertex.vertex_x) && $stable(vertex.vertex_y) && $stable(vertex.vertex_index) && $stable(vertex.last)), "vertex changed while waiting")

endmodule
